// ===== rtl/fbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT boot sector parser package
// Shared constants, the kept header record and the queue status record.
// ----------------------------------------------------------------------------
package fbsp_pkg;

  localparam int HEADER_BYTES = 52;
  localparam logic [5:0] POS_MAX = 6'd63;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  JMP_ALT      = 8'h69;
  localparam logic [7:0]  JMP_NEAR     = 8'he9;
  localparam logic [7:0]  JMP_SHORT    = 8'heb;
  localparam logic [7:0]  NOP_OPCODE   = 8'h90;
  localparam logic [7:0]  MEDIA_MIN    = 8'hf0;
  localparam logic [15:0] SECTOR_BYTES = 16'd512;
  localparam logic [7:0]  FAT_COUNT_STD = 8'd2;
  localparam logic [7:0]  FAT_COUNT_MAX = 8'd16;
  localparam logic [31:0] CLUSTER_MIN  = 32'd2;
  localparam logic [31:0] FAT12_LIMIT  = 32'hff6;
  localparam logic [4:0]  SECTOR_SHIFT = 5'd9;

  // floor(n / 3) for 16-bit n is (n * DIV3_MULT) >> DIV3_SHIFT.
  localparam logic [32:0] DIV3_MULT  = 33'd87382;
  localparam int          DIV3_SHIFT = 18;
  // 1024 = 3 * 341 + 1
  localparam logic [24:0] KB_DIV3    = 25'd341;

  localparam logic [1:0] FAT_TYPE_12 = 2'd0;
  localparam logic [1:0] FAT_TYPE_16 = 2'd1;
  localparam logic [1:0] FAT_TYPE_32 = 2'd2;

  localparam int OUT_DATA_W = 176;

  typedef struct packed {
    logic [7:0]  jump0;
    logic [7:0]  jump2;
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_count;
    logic [15:0] root_entries;
    logic [15:0] total_sectors16;
    logic [7:0]  media;
    logic [15:0] sectors_per_fat16;
    logic [31:0] total_sectors32;
    logic [31:0] sectors_per_fat32;
    logic [31:0] root_cluster;
  } hdr_t;

  typedef struct packed {
    logic full;
    logic avail;
  } queue_status_t;

  function automatic hdr_t hdr_write(hdr_t h, logic [5:0] pos, logic [7:0] b);
    hdr_t r;
    r = h;
    if ({1'b0, pos} < 7'(HEADER_BYTES)) begin
      unique case (pos)
        6'd0:  r.jump0 = b;
        6'd2:  r.jump2 = b;
        6'd11: r.bytes_per_sector[7:0] = b;
        6'd12: r.bytes_per_sector[15:8] = b;
        6'd13: r.sectors_per_cluster = b;
        6'd14: r.reserved_sectors[7:0] = b;
        6'd15: r.reserved_sectors[15:8] = b;
        6'd16: r.fat_count = b;
        6'd17: r.root_entries[7:0] = b;
        6'd18: r.root_entries[15:8] = b;
        6'd19: r.total_sectors16[7:0] = b;
        6'd20: r.total_sectors16[15:8] = b;
        6'd21: r.media = b;
        6'd22: r.sectors_per_fat16[7:0] = b;
        6'd23: r.sectors_per_fat16[15:8] = b;
        6'd32: r.total_sectors32[7:0] = b;
        6'd33: r.total_sectors32[15:8] = b;
        6'd34: r.total_sectors32[23:16] = b;
        6'd35: r.total_sectors32[31:24] = b;
        6'd36: r.sectors_per_fat32[7:0] = b;
        6'd37: r.sectors_per_fat32[15:8] = b;
        6'd38: r.sectors_per_fat32[23:16] = b;
        6'd39: r.sectors_per_fat32[31:24] = b;
        6'd44: r.root_cluster[7:0] = b;
        6'd45: r.root_cluster[15:8] = b;
        6'd46: r.root_cluster[23:16] = b;
        6'd47: r.root_cluster[31:24] = b;
        default: ;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/fbsp_front.sv =====
// ----------------------------------------------------------------------------
// FAT boot sector parser front end
// Takes sector bytes, keeps the header fields and queues a header snapshot
// on the last byte of each sector.
// ----------------------------------------------------------------------------
module fbsp_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,  // data_byte
  input  logic                    s_axis_tlast,  // last_byte
  input  fbsp_pkg::queue_status_t q_status,
  output logic                    push,
  output fbsp_pkg::hdr_t          push_hdr
);

  logic           accept;
  logic [5:0]     pos;
  logic [5:0]     pos_next;
  fbsp_pkg::hdr_t hdr;
  fbsp_pkg::hdr_t hdr_next;

  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hdr_next      = fbsp_pkg::hdr_write(hdr, pos, s_axis_tdata);
  assign push          = accept && s_axis_tlast;
  assign push_hdr      = hdr_next;

  always_comb begin
    pos_next = pos;
    if (s_axis_tlast) begin
      pos_next = '0;
    end else if (pos != fbsp_pkg::POS_MAX) begin
      pos_next = pos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      hdr <= '0;
    end else if (accept) begin
      pos <= pos_next;
      hdr <= hdr_next;
    end
  end

endmodule

// ===== rtl/fbsp_queue.sv =====
// ----------------------------------------------------------------------------
// FAT boot sector parser header queue
// Short queue of header snapshots between the front end and the back end.
// ----------------------------------------------------------------------------
module fbsp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  fbsp_pkg::hdr_t          push_hdr,
  input  logic                    pop,
  output fbsp_pkg::queue_status_t q_status,
  output fbsp_pkg::hdr_t          head
);

  fbsp_pkg::hdr_t                slots [fbsp_pkg::QUEUE_DEPTH];
  logic [fbsp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [fbsp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [fbsp_pkg::QCNT_W-1:0]   count;

  assign q_status.full  = (count == fbsp_pkg::QCNT_W'(fbsp_pkg::QUEUE_DEPTH));
  assign q_status.avail = (count != '0);
  assign head           = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == fbsp_pkg::QPTR_W'(fbsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == fbsp_pkg::QPTR_W'(fbsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/fbsp_back.sv =====
// ----------------------------------------------------------------------------
// FAT boot sector parser back end
// Five-stage pipeline that checks a header snapshot and works out the
// volume geometry, ending in the output register.
// ----------------------------------------------------------------------------
module fbsp_back (
  input  logic                                clk,
  input  logic                                rst,
  input  fbsp_pkg::queue_status_t             q_status,
  input  fbsp_pkg::hdr_t                      head,
  output logic                                pop,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fbsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [0:0]                          m_axis_tuser
);

  logic advance;

  // Stage A
  logic        jump_ok, spc_ok, fat1216, branch_ok, hdr_ok;
  logic [31:0] spf_sel, sc_sel;
  logic [2:0]  lg_sel;
  logic        a_valid, a_ok, a_fat1216;
  logic [31:0] a_spf, a_prod, a_rdcl, a_sc;
  logic [15:0] a_rsvd, a_dirents;
  logic [7:0]  a_spc;
  logic [2:0]  a_lg;

  // Stage B
  logic [32:0] div3_prod;
  logic        b_valid, b_ok, b_fat1216;
  logic [31:0] b_spf, b_lsndir, b_rdcl, b_sc;
  logic [14:0] b_q3;
  logic [24:0] b_m341;
  logic [15:0] b_rsvd, b_dirents;
  logic [7:0]  b_spc;
  logic [2:0]  b_lg;

  // Stage C
  logic [31:0] lsndta;
  logic        c_valid, c_ok, c_fat1216;
  logic [31:0] c_lsndir, c_lsndta, c_diff, c_cap12, c_cap16, c_cap32, c_rdcl;
  logic [15:0] c_rsvd, c_dirents;
  logic [7:0]  c_spc;
  logic [2:0]  c_lg;

  // Stage D
  logic        d_valid, d_ok, d_fat1216;
  logic [31:0] d_xclus, d_cap12, d_cap16, d_cap32, d_lsndir, d_lsndta, d_rdcl;
  logic [15:0] d_rsvd, d_dirents;
  logic [7:0]  d_spc;
  logic [2:0]  d_lg;

  // Output stage
  logic        e_ok;
  logic [1:0]  e_type;
  logic [31:0] e_cap, e_xclus;
  logic [fbsp_pkg::OUT_DATA_W-1:0] e_data;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign pop     = advance && q_status.avail;

  always_comb begin
    jump_ok = (head.jump0 == fbsp_pkg::JMP_ALT) || (head.jump0 == fbsp_pkg::JMP_NEAR) ||
              ((head.jump0 == fbsp_pkg::JMP_SHORT) && (head.jump2 == fbsp_pkg::NOP_OPCODE));
    spc_ok  = (head.sectors_per_cluster != 8'd0) &&
              ((head.sectors_per_cluster & (head.sectors_per_cluster - 8'd1)) == 8'd0);
    fat1216 = (head.sectors_per_fat16 != 16'd0);
    if (fat1216) begin
      branch_ok = (head.fat_count == fbsp_pkg::FAT_COUNT_STD) && (head.root_entries != 16'd0);
      spf_sel   = {16'd0, head.sectors_per_fat16};
    end else begin
      branch_ok = (head.sectors_per_fat32 != 32'd0) && (head.fat_count != 8'd0) &&
                  (head.fat_count <= fbsp_pkg::FAT_COUNT_MAX) &&
                  (head.root_cluster >= fbsp_pkg::CLUSTER_MIN);
      spf_sel   = head.sectors_per_fat32;
    end
    sc_sel = (head.total_sectors16 != 16'd0) ? {16'd0, head.total_sectors16}
                                             : head.total_sectors32;
    hdr_ok = jump_ok && (head.media >= fbsp_pkg::MEDIA_MIN) &&
             (head.bytes_per_sector == fbsp_pkg::SECTOR_BYTES) && spc_ok && branch_ok &&
             (head.reserved_sectors != 16'd0) && (sc_sel != 32'd0);
    lg_sel = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (head.sectors_per_cluster[i]) begin
        lg_sel = 3'(i);
      end
    end
  end

  assign div3_prod = {17'd0, a_spf[15:0]} * fbsp_pkg::DIV3_MULT;
  assign lsndta    = b_lsndir + {16'd0, 4'd0, b_dirents[15:4]};

  always_comb begin
    e_ok = d_ok && (d_xclus >= fbsp_pkg::CLUSTER_MIN);
    if (!d_fat1216) begin
      e_type = fbsp_pkg::FAT_TYPE_32;
      e_cap  = d_cap32;
    end else if (d_xclus < fbsp_pkg::FAT12_LIMIT) begin
      e_type = fbsp_pkg::FAT_TYPE_12;
      e_cap  = d_cap12;
    end else begin
      e_type = fbsp_pkg::FAT_TYPE_16;
      e_cap  = d_cap16;
    end
    e_xclus = (d_xclus > e_cap) ? e_cap : d_xclus;
    e_data  = '0;
    if (e_ok) begin
      e_data[1:0]     = e_type;
      e_data[9:2]     = d_spc;
      e_data[14:10]   = fbsp_pkg::SECTOR_SHIFT + {2'd0, d_lg};
      e_data[30:15]   = d_rsvd;
      e_data[62:31]   = d_lsndir;
      e_data[94:63]   = d_lsndta;
      e_data[126:95]  = e_xclus;
      e_data[158:127] = d_rdcl;
      e_data[174:159] = d_dirents;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
      d_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      a_valid       <= q_status.avail;
      b_valid       <= a_valid;
      c_valid       <= b_valid;
      d_valid       <= c_valid;
      m_axis_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_ok      <= hdr_ok;
      a_fat1216 <= fat1216;
      a_spf     <= spf_sel;
      a_prod    <= 32'(spf_sel * {24'd0, head.fat_count});
      a_rsvd    <= head.reserved_sectors;
      a_dirents <= fat1216 ? head.root_entries : 16'd0;
      a_rdcl    <= fat1216 ? 32'd0 : head.root_cluster;
      a_sc      <= sc_sel;
      a_spc     <= head.sectors_per_cluster;
      a_lg      <= lg_sel;

      b_ok      <= a_ok;
      b_fat1216 <= a_fat1216;
      b_spf     <= a_spf;
      b_lsndir  <= {16'd0, a_rsvd} + a_prod;
      b_q3      <= div3_prod[32:fbsp_pkg::DIV3_SHIFT];
      b_m341    <= {9'd0, a_spf[15:0]} * fbsp_pkg::KB_DIV3;
      b_rsvd    <= a_rsvd;
      b_dirents <= a_dirents;
      b_rdcl    <= a_rdcl;
      b_sc      <= a_sc;
      b_spc     <= a_spc;
      b_lg      <= a_lg;

      c_ok      <= b_ok && !(lsndta > b_sc);
      c_fat1216 <= b_fat1216;
      c_lsndir  <= b_lsndir;
      c_lsndta  <= lsndta;
      c_diff    <= b_sc - lsndta;
      c_cap12   <= {7'd0, b_m341} + {17'd0, b_q3} - 32'd1;
      c_cap16   <= {8'd0, b_spf[15:0], 8'd0} - 32'd1;
      c_cap32   <= {3'd0, b_spf[21:0], 7'd0} - 32'd1;
      c_rsvd    <= b_rsvd;
      c_dirents <= b_dirents;
      c_rdcl    <= b_rdcl;
      c_spc     <= b_spc;
      c_lg      <= b_lg;

      d_ok      <= c_ok;
      d_fat1216 <= c_fat1216;
      d_xclus   <= (c_diff >> c_lg) + 32'd1;
      d_cap12   <= c_cap12;
      d_cap16   <= c_cap16;
      d_cap32   <= c_cap32;
      d_lsndir  <= c_lsndir;
      d_lsndta  <= c_lsndta;
      d_rsvd    <= c_rsvd;
      d_dirents <= c_dirents;
      d_rdcl    <= c_rdcl;
      d_spc     <= c_spc;
      d_lg      <= c_lg;

      if (d_valid) begin
        m_axis_tdata <= e_data;
        m_axis_tuser <= e_ok;
      end
    end
  end

endmodule

// ===== rtl/fat_boot_sector_parser_unit.sv =====
// ----------------------------------------------------------------------------
// FAT boot sector parser
// Reads a FAT12/16/32 boot sector byte by byte and reports the volume layout.
// ----------------------------------------------------------------------------
// One sector byte is taken on every clock while s_axis_tready is high. The
// transfer with tlast set closes the sector and produces one result transfer
// through the five-stage geometry pipeline; a failed check gives tuser low
// and all-zero data. Up to two sector summaries wait in the queue between
// the byte front end and the pipeline, so s_axis_tready falls only when the
// output is held back for long enough to fill it.
module fat_boot_sector_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // data_byte
  input  logic                              s_axis_tlast,  // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fat_type[1:0], sectors_per_cluster[9:2], cluster_shift[14:10],
  // fat_start_sector[30:15], dir_start_sector[62:31], data_start_sector[94:63],
  // max_cluster[126:95], root_cluster[158:127], root_entries[174:159], zero[175]
  output logic [fbsp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [0:0]                        m_axis_tuser   // valid_res
);

  fbsp_pkg::queue_status_t q_status;
  fbsp_pkg::hdr_t          push_hdr;
  fbsp_pkg::hdr_t          head;
  logic                    push;
  logic                    pop;

  fbsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_status      (q_status),
    .push          (push),
    .push_hdr      (push_hdr)
  );

  fbsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_hdr (push_hdr),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  fbsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/fbsp_checker.sv =====
// ----------------------------------------------------------------------------
// FAT boot sector parser checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fbsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fbsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Result changed while stalled.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("Failed result carries non-zero fields.");

  a_spc_shift: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      $onehot(m_axis_tdata[9:2]) && (m_axis_tdata[14:10] >= fbsp_pkg::SECTOR_SHIFT) &&
      (m_axis_tdata[1:0] != 2'd3))
    else $error("Good result has bad cluster size or type.");

  a_type_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      ((m_axis_tdata[1:0] == fbsp_pkg::FAT_TYPE_32) ? (m_axis_tdata[174:159] == 16'd0)
                                                    : (m_axis_tdata[158:127] == 32'd0)))
    else $error("Root fields do not match the FAT type.");

endmodule

bind fat_boot_sector_parser_unit fbsp_checker u_fbsp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/fat_boot_sector_parser_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT boot sector parser testbench
// Streams FAT12/16/32 boot sectors into the parser one byte per transfer.
// Each closing byte is predicted from a local copy of the kept header and
// every result transfer is checked field by field. Directed sectors cover
// each check and boundary. Random sectors then mix well-formed volumes with
// corrupted, short and long sectors. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module fat_boot_sector_parser_unit_test;

  typedef struct packed {
    logic        pad;
    logic [15:0] root_entries;
    logic [31:0] root_cluster;
    logic [31:0] max_cluster;
    logic [31:0] data_start_sector;
    logic [31:0] dir_start_sector;
    logic [15:0] fat_start_sector;
    logic [4:0]  cluster_shift;
    logic [7:0]  sectors_per_cluster;
    logic [1:0]  fat_type;
  } sector_geometry_t;

  typedef struct packed {
    logic             valid_res;
    sector_geometry_t geo;
  } sector_result_t;

  class boot_sector_scoreboard;
    logic [7:0]     header [fbsp_pkg::HEADER_BYTES];
    logic [5:0]     position;
    sector_result_t pending_geometry [$];
    int             errors;
    int             sectors_closed;

    function new();
      foreach (header[i]) header[i] = 8'h00;
      position = 6'd0;
      errors = 0;
      sectors_closed = 0;
    endfunction

    function bit [31:0] le16(int i);
      return {16'h0000, header[i + 1], header[i]};
    endfunction

    function bit [31:0] le32(int i);
      return {header[i + 3], header[i + 2], header[i + 1], header[i]};
    endfunction

    function int pending();
      return pending_geometry.size();
    endfunction

    function void take_sector_byte(logic [7:0] data_byte, logic last_byte);
      bit [31:0] spc, fats, spf, dirents, rdcl, lsnfat, lsndir, lsndta;
      bit [31:0] total, xclus, cap, shift, width_bits, t;
      bit [1:0] kind;
      bit ok;
      sector_result_t r;
      if (position < fbsp_pkg::HEADER_BYTES) header[position] = data_byte;
      if (!last_byte) begin
        if (position != fbsp_pkg::POS_MAX) position++;
        return;
      end
      position = 6'd0;
      sectors_closed++;
      spc = 32'(header[13]);
      fats = 32'(header[16]);
      ok = (header[0] == fbsp_pkg::JMP_ALT || header[0] == fbsp_pkg::JMP_NEAR ||
            (header[0] == fbsp_pkg::JMP_SHORT && header[2] == fbsp_pkg::NOP_OPCODE)) &&
           header[21] >= fbsp_pkg::MEDIA_MIN && le16(11) == 32'(fbsp_pkg::SECTOR_BYTES) &&
           spc != 0 && (spc & (spc - 1)) == 0;
      shift = 32'(fbsp_pkg::SECTOR_SHIFT);
      for (t = spc; t > 1; t = t >> 1) shift++;
      dirents = 0;
      rdcl = 0;
      spf = le16(22);
      if (spf != 0) begin
        if (fats != 32'(fbsp_pkg::FAT_COUNT_STD)) ok = 0;
        dirents = le16(17);
        if (dirents == 0) ok = 0;
      end else begin
        spf = le32(36);
        if (spf == 0 || fats == 0 || fats > 32'(fbsp_pkg::FAT_COUNT_MAX)) ok = 0;
        rdcl = le32(44);
        if (rdcl < fbsp_pkg::CLUSTER_MIN) ok = 0;
      end
      lsnfat = le16(14);
      if (lsnfat == 0) ok = 0;
      lsndir = lsnfat + spf * fats;
      lsndta = lsndir + (dirents >> 4);
      total = le16(19);
      if (total == 0) total = le32(32);
      if (total == 0 || lsndta > total) ok = 0;
      xclus = ((total - lsndta) >> (shift - 32'(fbsp_pkg::SECTOR_SHIFT))) + 1;
      if (xclus < fbsp_pkg::CLUSTER_MIN) ok = 0;
      if (dirents != 0) begin
        kind = (xclus < fbsp_pkg::FAT12_LIMIT) ? fbsp_pkg::FAT_TYPE_12 : fbsp_pkg::FAT_TYPE_16;
        width_bits = (kind == fbsp_pkg::FAT_TYPE_12) ? 12 : 16;
      end else begin
        kind = fbsp_pkg::FAT_TYPE_32;
        width_bits = 32;
      end
      cap = ((spf << 10) / (width_bits >> 2)) - 1;
      if (xclus > cap) xclus = cap;
      r = '0;
      if (ok) begin
        r.valid_res = 1'b1;
        r.geo.fat_type = kind;
        r.geo.sectors_per_cluster = spc[7:0];
        r.geo.cluster_shift = shift[4:0];
        r.geo.fat_start_sector = lsnfat[15:0];
        r.geo.dir_start_sector = lsndir;
        r.geo.data_start_sector = lsndta;
        r.geo.max_cluster = xclus;
        r.geo.root_cluster = rdcl;
        r.geo.root_entries = dirents[15:0];
      end
      pending_geometry.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch in %s: expected %h, got %h.", name, want, got);
      end
    endfunction

    function void check_result(sector_geometry_t got, logic valid_res);
      sector_result_t want;
      if (pending_geometry.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Result transfer with no sector waiting: tuser %b, tdata %h.",
                   valid_res, got);
        return;
      end
      want = pending_geometry.pop_front();
      compare_field("valid_res", 32'(want.valid_res), 32'(valid_res));
      compare_field("fat_type", 32'(want.geo.fat_type), 32'(got.fat_type));
      compare_field("sectors_per_cluster", 32'(want.geo.sectors_per_cluster),
                    32'(got.sectors_per_cluster));
      compare_field("cluster_shift", 32'(want.geo.cluster_shift),
                    32'(got.cluster_shift));
      compare_field("fat_start_sector", 32'(want.geo.fat_start_sector),
                    32'(got.fat_start_sector));
      compare_field("dir_start_sector", want.geo.dir_start_sector,
                    got.dir_start_sector);
      compare_field("data_start_sector", want.geo.data_start_sector,
                    got.data_start_sector);
      compare_field("max_cluster", want.geo.max_cluster, got.max_cluster);
      compare_field("root_cluster", want.geo.root_cluster, got.root_cluster);
      compare_field("root_entries", 32'(want.geo.root_entries),
                    32'(got.root_entries));
      compare_field("pad", 32'(want.geo.pad), 32'(got.pad));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = 8'h00;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [fbsp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                      m_axis_tuser;

  boot_sector_scoreboard sb;
  logic [7:0] img [64];
  int  bytes_sent = 0;
  bit  src_quiet = 1'b0;
  bit  sink_quiet = 1'b0;

  fat_boot_sector_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
    int gap;
    if ($urandom_range(0, 63) == 0) src_quiet = ~src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = data_byte;
    s_axis_tlast = last_byte;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_sector_byte(data_byte, last_byte);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_sector(input int len);
    for (int i = 0; i < len; i++)
      send_byte((i < 64) ? img[i] : 8'($urandom), i == len - 1);
  endtask

  task automatic put16(input int off, input logic [15:0] v);
    img[off] = v[7:0];
    img[off + 1] = v[15:8];
  endtask

  task automatic put32(input int off, input logic [31:0] v);
    put16(off, v[15:0]);
    put16(off + 2, v[31:16]);
  endtask

  // Builds a consistent volume image; a zero clusters or spf and a negative lg_in are drawn at random.
  task automatic make_volume(input bit fat32, input int unsigned clusters,
                             input int unsigned spf, input int lg_in);
    int unsigned lg, spc, rsv, fats, dirs, dta, total;
    for (int i = 0; i < 64; i++) img[i] = 8'($urandom);
    case ($urandom_range(0, 2))
      0: img[0] = fbsp_pkg::JMP_ALT;
      1: img[0] = fbsp_pkg::JMP_NEAR;
      default: begin
        img[0] = fbsp_pkg::JMP_SHORT;
        img[2] = fbsp_pkg::NOP_OPCODE;
      end
    endcase
    lg = (lg_in < 0) ? $urandom_range(0, 7) : lg_in;
    spc = 1 << lg;
    img[13] = spc[7:0];
    put16(11, fbsp_pkg::SECTOR_BYTES);
    rsv = $urandom_range(1, 64);
    put16(14, rsv[15:0]);
    img[21] = 8'($urandom_range(fbsp_pkg::MEDIA_MIN, 255));
    if (!fat32) begin
      fats = 2;
      dirs = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 1024);
      if (spf == 0) spf = $urandom_range(1, 300);
      put16(22, spf[15:0]);
      put16(17, dirs[15:0]);
    end else begin
      fats = $urandom_range(1, 16);
      dirs = 0;
      if (spf == 0) spf = $urandom_range(1, 20000);
      put16(22, 16'h0000);
      put32(36, spf);
      put32(44, $urandom_range(2, 100000));
    end
    img[16] = fats[7:0];
    if (clusters == 0)
      case ($urandom_range(0, 3))
        0: clusters = $urandom_range(1, 64);
        1: clusters = $urandom_range(32'hfee, 32'hffe);
        2: clusters = $urandom_range(1, 70000);
        default: clusters = $urandom_range(1, 3000000);
      endcase
    dta = rsv + spf * fats + (dirs >> 4);
    total = dta + ((clusters - 1) << lg) + $urandom_range(0, spc - 1);
    if (total < 65536 && $urandom_range(0, 1) == 1) begin
      put16(19, total[15:0]);
    end else begin
      put16(19, 16'h0000);
      put32(32, total);
    end
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_quiet = ~sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(sector_geometry_t'(m_axis_tdata), m_axis_tuser[0]);
      @(negedge clk);
    end
  end

  initial begin
    int len, pick, k;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int n = 0; n < 25; n++) begin
      len = 52;
      make_volume(n inside {4, 13, 14, 15, 16, 17, 22}, 0, 0, -1);
      case (n)
        0: begin
          img[0] = 8'hff;
          len = 1;
        end
        1: make_volume(1'b0, 100, 8, 0);
        2: make_volume(1'b0, 32'hff5, 20, -1);
        3: make_volume(1'b0, 32'hff6, 20, -1);
        4: begin
          make_volume(1'b1, 100000, 0, 7);
          img[0] = fbsp_pkg::JMP_SHORT;
          img[2] = fbsp_pkg::NOP_OPCODE;
        end
        5: begin
          img[0] = fbsp_pkg::JMP_SHORT;
          img[2] = 8'h91;
        end
        6: img[0] = 8'h00;
        7: img[21] = 8'hef;
        8: put16(11, 16'd1024);
        9: img[13] = 8'h00;
        10: img[13] = 8'h03;
        11: img[16] = 8'd1;
        12: put16(17, 16'h0000);
        13: put32(36, 32'h0);
        14: img[16] = 8'd0;
        15: img[16] = 8'd17;
        16: put32(44, 32'd1);
        17: put32(44, 32'hffffffff);
        18: put16(14, 16'h0000);
        19: begin
          put16(19, 16'h0000);
          put32(32, 32'h0);
        end
        20: make_volume(1'b0, 1, 0, -1);
        21: make_volume(1'b0, 70000, 1, 0);
        22: put32(36, 32'hffffffff);
        23: len = 20;
        default: len = 100;
      endcase
      send_sector(len);
    end

    while (bytes_sent < 1300) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        for (int i = 0; i < 64; i++) img[i] = 8'($urandom);
      end else begin
        make_volume($urandom_range(0, 1), 0, 0, -1);
      end
      if (pick >= 1 && pick <= 3) img[$urandom_range(0, 51)] = 8'($urandom);
      if (pick == 4) begin
        k = $urandom_range(0, 51);
        img[k][$urandom_range(0, 7)] ^= 1'b1;
      end
      case ($urandom_range(0, 15))
        0: len = $urandom_range(1, 51);
        1: len = $urandom_range(65, 100);
        default: len = $urandom_range(52, 64);
      endcase
      send_sector(len);
    end
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
